// ===== src/upfp_pkg.sv =====
// Shared types and constants for the ultra-prominent peak finder.
// Request and result payloads, controller/datapath command and status groups.
// No dependencies.
`default_nettype none

package upfp_pkg;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	localparam int ElevW  = 24;
	localparam int QIdxW  = 12;
	localparam int CountW = 13;

	localparam logic [ElevW-1:0] THRESHOLD_RESET = 24'd150000;

	typedef logic [ElevW-1:0] elev_t;

	typedef struct packed {
		logic              cmd;
		elev_t             elevation;
		logic              last;
		logic [QIdxW-1:0]  query_index;
	} request_t;

	typedef struct packed {
		logic              result_kind;
		logic [CountW-1:0] ultra_count;
		logic              is_ultra;
		logic              overflow;
	} result_t;

	typedef struct packed {
		logic load;
		logic query;
		logic init_fwd;
		logic init_bwd;
		logic cmp;
		logic report;
		logic answer;
	} ctl_cmd_t;

	typedef struct packed {
		logic pop;
		logic last_k;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== src/upfp_ctrl.sv =====
// Controller state machine of the peak finder: load/query dispatch and stack pass sequencing.
// Depends on upfp_pkg.
`default_nettype none

module upfp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              req_query,
	input  wire logic              req_last,
	input  wire upfp_pkg::ctl_sts_t sts,
	output upfp_pkg::ctl_cmd_t     cmd,
	output logic                   busy
);

	typedef enum logic [2:0] {
		IDLE, FWD_RD, FWD_CMP, BWD_RD, BWD_CMP, REPORT, ANSWER
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (start) begin
					if (req_query == upfp_pkg::CMD_QUERY) begin
						cmd.query = 1'b1;
						state_d   = ANSWER;
					end else begin
						cmd.load = 1'b1;
						if (req_last) begin
							cmd.init_fwd = 1'b1;
							state_d      = FWD_RD;
						end
					end
				end
			end
			FWD_RD:  state_d = FWD_CMP;
			FWD_CMP: begin
				cmd.cmp = 1'b1;
				if (!sts.pop) begin
					if (sts.last_k) begin
						cmd.init_bwd = 1'b1;
						state_d      = BWD_RD;
					end else begin
						state_d = FWD_RD;
					end
				end
			end
			BWD_RD:  state_d = BWD_CMP;
			BWD_CMP: begin
				cmd.cmp = 1'b1;
				if (!sts.pop) state_d = sts.last_k ? REPORT : BWD_RD;
			end
			REPORT: begin
				cmd.report = 1'b1;
				state_d    = IDLE;
			end
			ANSWER: begin
				cmd.answer = 1'b1;
				state_d    = IDLE;
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != IDLE);
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

// ===== src/upfp_dp.sv =====
// Datapath of the peak finder: sample, stack and flag memories, counters, result register.
// Depends on upfp_pkg; driven by upfp_ctrl.
`default_nettype none

module upfp_dp #(
	parameter int MAX_SAMPLES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire upfp_pkg::request_t request,
	input  wire logic               cfg_valid,
	input  wire upfp_pkg::elev_t    cfg_data,
	input  wire upfp_pkg::ctl_cmd_t cmd,
	output upfp_pkg::ctl_sts_t      sts,
	output upfp_pkg::result_t       result,
	output logic                    result_strobe
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int EW = upfp_pkg::ElevW;

	typedef struct packed {
		upfp_pkg::elev_t h;
		upfp_pkg::elev_t mn;
	} stk_t;

	upfp_pkg::elev_t height_mem [MAX_SAMPLES];
	stk_t            stack_mem  [MAX_SAMPLES];
	logic            left_mem   [MAX_SAMPLES];
	logic            res_mem    [MAX_SAMPLES];

	upfp_pkg::elev_t thr_q, max_q, h_rd_q, mn_q;
	stk_t            top_rd_q;
	logic            left_rd_q, res_rd_q, have_q, bwd_q, computed_q, ov_q, q_ok_q;
	logic [CW-1:0]   cnt_q, k_q, depth_q, qcnt_q;
	upfp_pkg::result_t res_q;
	logic            strobe_q;

	logic [CW-1:0]   base;
	logic            full;
	logic [CW-1:0]   cur_i;
	logic [AW-1:0]   stk_addr;
	logic            ok, flag, pop;
	upfp_pkg::elev_t mn_new, push_mn;

	// load position: a load after a computation starts a new profile
	assign base  = computed_q ? '0 : cnt_q;
	assign full  = (base == CW'(MAX_SAMPLES));
	assign cur_i = bwd_q ? (cnt_q - CW'(1) - k_q) : k_q;

	assign pop         = (depth_q != '0) && (top_rd_q.h <= h_rd_q);
	assign sts.pop     = pop;
	assign sts.last_k  = (k_q == cnt_q - CW'(1));
	assign stk_addr    = (cmd.cmp && pop) ? AW'(depth_q - CW'(2)) : AW'(depth_q - CW'(1));
	assign mn_new      = (have_q && mn_q < top_rd_q.mn) ? mn_q : top_rd_q.mn;
	assign push_mn     = (have_q && mn_q < h_rd_q) ? mn_q : h_rd_q;

	always_comb begin
		ok = (depth_q == '0) || (have_q && (EW'(h_rd_q - mn_q) >= thr_q));
		if (!bwd_q) begin
			flag = (h_rd_q != max_q) && ok;
		end else if (h_rd_q == max_q) begin
			flag = (max_q >= thr_q);
		end else begin
			flag = left_rd_q && ok;
		end
	end

	// memories: no reset, every entry that is used is written before it is read
	always_ff @(posedge clk) begin
		if (cmd.load && !full) height_mem[AW'(base)] <= request.elevation;
		h_rd_q <= height_mem[AW'(cur_i)];
		left_rd_q <= left_mem[AW'(cur_i)];
		top_rd_q <= stack_mem[stk_addr];
		res_rd_q <= res_mem[AW'(request.query_index)];
		if (cmd.cmp && !pop) begin
			stack_mem[AW'(depth_q)] <= '{h: h_rd_q, mn: push_mn};
			if (bwd_q) res_mem[AW'(cur_i)] <= flag;
			else       left_mem[AW'(cur_i)] <= flag;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_fwd || cmd.init_bwd || (cmd.cmp && !pop)) begin
			have_q <= 1'b0;
		end else if (cmd.cmp) begin
			have_q <= 1'b1;
		end
		if (cmd.cmp && pop) mn_q <= mn_new;
		if (cmd.query) q_ok_q <= (32'(request.query_index) < 32'(cnt_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= upfp_pkg::THRESHOLD_RESET;
			cnt_q      <= '0;
			max_q      <= '0;
			ov_q       <= 1'b0;
			computed_q <= 1'b0;
			qcnt_q     <= '0;
			k_q        <= '0;
			depth_q    <= '0;
			bwd_q      <= 1'b0;
			strobe_q   <= 1'b0;
			res_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) thr_q <= cfg_data;
			if (cmd.load) begin
				computed_q <= 1'b0;
				if (!full) begin
					cnt_q <= base + CW'(1);
					max_q <= (computed_q || request.elevation > max_q) ?
						request.elevation : max_q;
					if (computed_q) ov_q <= 1'b0;
				end else begin
					cnt_q <= base;
					ov_q  <= 1'b1;
				end
			end
			// a pass start resets the pass; the backward start takes the place of the final forward push's advance
			if (cmd.init_fwd || cmd.init_bwd) begin
				k_q     <= '0;
				depth_q <= '0;
				bwd_q   <= cmd.init_bwd;
				if (cmd.init_fwd) qcnt_q <= '0;
			end else if (cmd.cmp) begin
				if (pop) begin
					depth_q <= depth_q - CW'(1);
				end else begin
					depth_q <= depth_q + CW'(1);
					k_q     <= k_q + CW'(1);
					if (bwd_q && flag) qcnt_q <= qcnt_q + CW'(1);
				end
			end
			if (cmd.report) begin
				computed_q        <= 1'b1;
				strobe_q          <= 1'b1;
				res_q.result_kind <= upfp_pkg::KIND_REPORT;
				res_q.ultra_count <= upfp_pkg::CountW'(qcnt_q);
				res_q.is_ultra    <= 1'b0;
				res_q.overflow    <= ov_q;
			end
			if (cmd.answer) begin
				strobe_q          <= 1'b1;
				res_q.result_kind <= upfp_pkg::KIND_ANSWER;
				res_q.ultra_count <= computed_q ? upfp_pkg::CountW'(qcnt_q) : '0;
				res_q.is_ultra    <= computed_q && q_ok_q && res_rd_q;
				res_q.overflow    <= ov_q;
			end
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

// ===== src/ultra_prominent_peak_finder_core.sv =====
// Top level of the ultra-prominent peak finder: controller plus datapath.
// Depends on upfp_pkg, upfp_ctrl and upfp_dp.
//
// Usage: present a request and raise start; it is taken at an edge where busy is low.
// A load (cmd 0) stores one elevation and gives no result unless it is marked last.
// The last load runs a forward and a backward monotonic-stack pass over the stored
// profile, then pulses result_strobe for one cycle with a report (result_kind 0).
// Busy stays high through both passes. Each takes a memory read state and a compare
// state per sample, plus a further compare state per stack pop; for n samples the
// pops of both passes number at most 2n - 2. The report is on the ports in the cycle
// in which busy falls. A query (cmd 1) is answered from the ANSWER state, with busy
// high while in it and the strobe in the cycle in which busy falls. Loads beyond
// MAX_SAMPLES are dropped and set the overflow bit. The threshold is written on the
// cfg channel (always ready); the user must write it only while idle, as the block
// does not enforce it. Reset clears counts, the maximum and the computed mark, and
// loads the default threshold; memories are not cleared and need no clearing pass.
// Results cannot be held off: a result is valid only in its strobe cycle.
`default_nettype none

module ultra_prominent_peak_finder_core #(
	parameter int MAX_SAMPLES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire upfp_pkg::request_t request,
	output upfp_pkg::result_t       result,
	output logic                    result_strobe,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire upfp_pkg::elev_t    cfg_data
);

	upfp_pkg::ctl_cmd_t cmd;
	upfp_pkg::ctl_sts_t sts;
	logic               accept;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	upfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.req_query (request.cmd),
		.req_last  (request.last),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	upfp_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.request       (request),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

`default_nettype wire

// ===== src/upfp_checker.sv =====
// Port-level checker for the peak finder top level, attached by bind.
// Depends on upfp_pkg and ultra_prominent_peak_finder_core.
`default_nettype none

module upfp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire upfp_pkg::request_t request,
	input wire upfp_pkg::result_t  result,
	input wire logic               result_strobe
);

	logic take;
	assign take = start && !busy;

	a_query_answer: assert property (@(posedge clk) disable iff (!arst_n)
		take && request.cmd == upfp_pkg::CMD_QUERY |-> ##2 result_strobe)
		else $error("query transfer not answered two cycles later");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && request.cmd == upfp_pkg::CMD_QUERY |=> busy)
		else $error("busy low right after query transfer");

	a_plain_load: assert property (@(posedge clk) disable iff (!arst_n)
		take && request.cmd == upfp_pkg::CMD_LOAD && !request.last |=> !busy && !result_strobe)
		else $error("plain load produced activity");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back to back result strobes");

	a_report_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.result_kind == upfp_pkg::KIND_REPORT |-> !result.is_ultra)
		else $error("report carries a query flag");

endmodule

bind ultra_prominent_peak_finder_core upfp_checker u_upfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.request       (request),
	.result        (result),
	.result_strobe (result_strobe)
);

`default_nettype wire
